// ===== rtl/stl_pkg.sv =====
package stl_pkg;

  localparam int BYTE_BITS  = 8;
  localparam int KIND_BITS  = 6;
  localparam int START_BITS = 16;
  localparam int LEN_BITS   = 16;
  localparam int ERR_BITS   = 2;

  localparam int KW_COUNT   = 7;
  localparam int KW_MAX_LEN = 6;
  localparam int KW_IDX_BITS = $clog2(KW_MAX_LEN);

  localparam logic [LEN_BITS-1:0] LEN_MAX = '1;

  // Token kinds.
  localparam logic [KIND_BITS-1:0] KIND_EOF      = 6'd0;
  localparam logic [KIND_BITS-1:0] KIND_NUMBER   = 6'd1;
  localparam logic [KIND_BITS-1:0] KIND_FLOAT    = 6'd2;
  localparam logic [KIND_BITS-1:0] KIND_STRING   = 6'd3;
  localparam logic [KIND_BITS-1:0] KIND_IDENT    = 6'd4;
  localparam logic [KIND_BITS-1:0] KIND_KW_IF    = 6'd5;
  localparam logic [KIND_BITS-1:0] KIND_PLUS     = 6'd12;
  localparam logic [KIND_BITS-1:0] KIND_PLUS_DOT = 6'd13;
  localparam logic [KIND_BITS-1:0] KIND_MINUS    = 6'd14;
  localparam logic [KIND_BITS-1:0] KIND_MINUS_DOT = 6'd15;
  localparam logic [KIND_BITS-1:0] KIND_STAR     = 6'd16;
  localparam logic [KIND_BITS-1:0] KIND_STAR_DOT = 6'd17;
  localparam logic [KIND_BITS-1:0] KIND_SLASH    = 6'd18;
  localparam logic [KIND_BITS-1:0] KIND_SLASH_DOT = 6'd19;
  localparam logic [KIND_BITS-1:0] KIND_PERCENT  = 6'd20;
  localparam logic [KIND_BITS-1:0] KIND_PERCENT_DOT = 6'd21;
  localparam logic [KIND_BITS-1:0] KIND_COMMA    = 6'd22;
  localparam logic [KIND_BITS-1:0] KIND_EQ_EQ    = 6'd23;
  localparam logic [KIND_BITS-1:0] KIND_EQ       = 6'd24;
  localparam logic [KIND_BITS-1:0] KIND_ASSIGN   = 6'd25;
  localparam logic [KIND_BITS-1:0] KIND_COLON    = 6'd26;
  localparam logic [KIND_BITS-1:0] KIND_SEMI     = 6'd27;
  localparam logic [KIND_BITS-1:0] KIND_LPAREN   = 6'd28;
  localparam logic [KIND_BITS-1:0] KIND_RPAREN   = 6'd29;
  localparam logic [KIND_BITS-1:0] KIND_LBRACE   = 6'd30;
  localparam logic [KIND_BITS-1:0] KIND_RBRACE   = 6'd31;
  localparam logic [KIND_BITS-1:0] KIND_NOT_EQ   = 6'd32;
  localparam logic [KIND_BITS-1:0] KIND_NOT      = 6'd33;
  localparam logic [KIND_BITS-1:0] KIND_GT_EQ    = 6'd34;
  localparam logic [KIND_BITS-1:0] KIND_GT       = 6'd35;
  localparam logic [KIND_BITS-1:0] KIND_LT_EQ    = 6'd36;
  localparam logic [KIND_BITS-1:0] KIND_LT       = 6'd37;
  localparam logic [KIND_BITS-1:0] KIND_HASH     = 6'd38;

  // Error codes.
  localparam logic [ERR_BITS-1:0] ERR_NONE    = 2'd0;
  localparam logic [ERR_BITS-1:0] ERR_DOTS    = 2'd1;
  localparam logic [ERR_BITS-1:0] ERR_STRING  = 2'd2;
  localparam logic [ERR_BITS-1:0] ERR_UNKNOWN = 2'd3;

  localparam logic [BYTE_BITS-1:0] KW_TEXT [KW_COUNT][KW_MAX_LEN] = '{
    '{"i", "f", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"t", "h", "e", "n", 8'h00, 8'h00},
    '{"e", "l", "s", "e", 8'h00, 8'h00},
    '{"l", "e", "t", 8'h00, 8'h00, 8'h00},
    '{"i", "n", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"e", "x", "t", "e", "r", "n"},
    '{"n", "e", "w", 8'h00, 8'h00, 8'h00}
  };
  localparam logic [2:0] KW_LEN [KW_COUNT] = '{3'd2, 3'd4, 3'd4, 3'd3, 3'd2, 3'd6, 3'd3};

  typedef struct packed {
    logic [BYTE_BITS-1:0] source_byte;
    logic                 end_of_source;
  } stl_text_t;

  typedef struct packed {
    logic [KIND_BITS-1:0]  token_kind;
    logic [START_BITS-1:0] token_start;
    logic [LEN_BITS-1:0]   token_length;
    logic [ERR_BITS-1:0]   error_code;
    logic                  last_of_run;
  } stl_token_t;

  function automatic stl_token_t make_token(logic [KIND_BITS-1:0] kind,
                                            logic [START_BITS-1:0] start,
                                            logic [LEN_BITS-1:0] len,
                                            logic [ERR_BITS-1:0] err);
    stl_token_t t;
    t.token_kind   = kind;
    t.token_start  = start;
    t.token_length = len;
    t.error_code   = err;
    t.last_of_run  = 1'b0;
    return t;
  endfunction

  function automatic logic is_digit(logic [BYTE_BITS-1:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_alpha(logic [BYTE_BITS-1:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic is_space(logic [BYTE_BITS-1:0] c);
    return c == " " || (c >= 8'd9 && c <= 8'd13);
  endfunction

  // Kind of a lone operator byte that may take a second byte; zero if none.
  function automatic logic [KIND_BITS-1:0] op_one(logic [BYTE_BITS-1:0] c);
    logic [KIND_BITS-1:0] k;
    case (c)
      "+":     k = KIND_PLUS;
      "-":     k = KIND_MINUS;
      "*":     k = KIND_STAR;
      "/":     k = KIND_SLASH;
      "%":     k = KIND_PERCENT;
      "=":     k = KIND_EQ;
      ":":     k = KIND_COLON;
      "!":     k = KIND_NOT;
      ">":     k = KIND_GT;
      "<":     k = KIND_LT;
      default: k = KIND_EOF;
    endcase
    return k;
  endfunction

  function automatic logic [KIND_BITS-1:0] op_two(logic [BYTE_BITS-1:0] c);
    logic [KIND_BITS-1:0] k;
    case (c)
      "+":     k = KIND_PLUS_DOT;
      "-":     k = KIND_MINUS_DOT;
      "*":     k = KIND_STAR_DOT;
      "/":     k = KIND_SLASH_DOT;
      "%":     k = KIND_PERCENT_DOT;
      "=":     k = KIND_EQ_EQ;
      ":":     k = KIND_ASSIGN;
      "!":     k = KIND_NOT_EQ;
      ">":     k = KIND_GT_EQ;
      "<":     k = KIND_LT_EQ;
      default: k = KIND_EOF;
    endcase
    return k;
  endfunction

  function automatic logic [BYTE_BITS-1:0] op_second(logic [BYTE_BITS-1:0] c);
    logic [BYTE_BITS-1:0] s;
    case (c)
      "+", "-", "*", "/", "%": s = ".";
      "=", ":", "!", ">", "<": s = "=";
      default:                 s = 8'h00;
    endcase
    return s;
  endfunction

  function automatic logic [KIND_BITS-1:0] single_kind(logic [BYTE_BITS-1:0] c);
    logic [KIND_BITS-1:0] k;
    case (c)
      ",":     k = KIND_COMMA;
      ";":     k = KIND_SEMI;
      "(":     k = KIND_LPAREN;
      ")":     k = KIND_RPAREN;
      "{":     k = KIND_LBRACE;
      "}":     k = KIND_RBRACE;
      "#":     k = KIND_HASH;
      default: k = KIND_EOF;
    endcase
    return k;
  endfunction

  // Drops every keyword that ends before this offset or whose character at it differs from c.
  function automatic logic [KW_COUNT-1:0] kw_filter(logic [KW_COUNT-1:0] cand,
                                                    logic [LEN_BITS-1:0] count,
                                                    logic [BYTE_BITS-1:0] c);
    logic [KW_COUNT-1:0] keep;
    keep = cand;
    for (int k = 0; k < KW_COUNT; k++) begin
      if (count >= LEN_BITS'(KW_LEN[k])) begin
        keep[k] = 1'b0;
      end else if (KW_TEXT[k][count[KW_IDX_BITS-1:0]] != c) begin
        keep[k] = 1'b0;
      end
    end
    return keep;
  endfunction

  // The first surviving keyword of exactly this length wins.
  function automatic logic [KIND_BITS-1:0] kw_kind(logic [KW_COUNT-1:0] cand,
                                                   logic [LEN_BITS-1:0] count);
    logic [KIND_BITS-1:0] kind;
    kind = KIND_IDENT;
    for (int k = KW_COUNT - 1; k >= 0; k--) begin
      if (cand[k] && count == LEN_BITS'(KW_LEN[k])) begin
        kind = KIND_KW_IF + KIND_BITS'(k);
      end
    end
    return kind;
  endfunction

endpackage

// ===== rtl/stl_if.sv =====
interface stl_text_if import stl_pkg::*; ();
  logic      valid;
  logic      ready;
  stl_text_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface stl_token_if import stl_pkg::*; ();
  logic       valid;
  logic       ready;
  stl_token_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/source_token_lexer.sv =====
// Streaming lexer: one source byte is taken per clock while the four-entry
// token queue has room for two tokens, and its tokens (none, one or two)
// are in the queue from the cycle after the byte is taken. Tokens leave the
// queue one per cycle while the consumer is ready, so a byte that completes
// two tokens holds the input back only when the queue fills. Scan state
// is plain registers cleared by reset; there is no start-up delay. After
// an error token the block takes bytes but emits nothing more until reset.
module source_token_lexer import stl_pkg::*; #(
  parameter int POSITION_BITS = 16
) (
  input logic        clk,
  input logic        rst,
  stl_text_if.sink   text,
  stl_token_if.source tokens
);

  localparam logic [2:0] MODE_IDLE   = 3'd0;
  localparam logic [2:0] MODE_NUMBER = 3'd1;
  localparam logic [2:0] MODE_IDENT  = 3'd2;
  localparam logic [2:0] MODE_STRING = 3'd3;
  localparam logic [2:0] MODE_OPER   = 3'd4;

  localparam int FIFO_DEPTH = 4;
  localparam int PTR_BITS   = $clog2(FIFO_DEPTH);
  localparam int CNT_BITS   = $clog2(FIFO_DEPTH + 1);

  logic [POSITION_BITS-1:0] byte_position, byte_position_next;
  logic [POSITION_BITS-1:0] token_begin, token_begin_next;
  logic [2:0]               scan_mode, scan_mode_next;
  logic                     dot_seen, dot_seen_next;
  logic [KW_COUNT-1:0]      keyword_candidates, keyword_candidates_next;
  logic [BYTE_BITS-1:0]     pending_operator, pending_operator_next;
  logic                     error_latched, error_latched_next;
  logic [LEN_BITS-1:0]      token_count, token_count_next;

  logic [BYTE_BITS-1:0]  c;
  logic                  at_end;
  logic                  accept;
  logic                  pop;
  logic [START_BITS-1:0] pos16;
  logic [LEN_BITS-1:0]   count_inc;
  logic                  flush_ok, flush_used, start_used, second_ok;
  stl_token_t            flush_item, second_item, res0, res1;
  logic [1:0]            res_count;

  stl_token_t             fifo_mem [FIFO_DEPTH];
  logic [PTR_BITS-1:0]    wr_ptr, rd_ptr;
  logic [CNT_BITS-1:0]    fifo_count;

  assign c         = text.data.source_byte;
  assign at_end    = text.data.end_of_source || c == 8'h00;
  assign pos16     = START_BITS'(byte_position);
  assign count_inc = (token_count == LEN_MAX) ? token_count : token_count + 1'b1;

  // Token that a non-continuing byte closes, from the current scan state.
  always_comb begin
    flush_ok   = 1'b0;
    flush_item = make_token(KIND_EOF, START_BITS'(token_begin), token_count, ERR_NONE);
    case (scan_mode)
      MODE_NUMBER: begin
        flush_ok = 1'b1;
        flush_item.token_kind = dot_seen ? KIND_FLOAT : KIND_NUMBER;
      end
      MODE_IDENT: begin
        flush_ok = 1'b1;
        flush_item.token_kind = kw_kind(keyword_candidates, token_count);
      end
      MODE_OPER: begin
        flush_ok = 1'b1;
        flush_item.token_kind   = op_one(pending_operator);
        flush_item.token_length = LEN_BITS'(1);
      end
      default: flush_ok = 1'b0;
    endcase
  end

  always_comb begin
    byte_position_next      = byte_position;
    token_begin_next        = token_begin;
    scan_mode_next          = scan_mode;
    dot_seen_next           = dot_seen;
    keyword_candidates_next = keyword_candidates;
    pending_operator_next   = pending_operator;
    error_latched_next      = error_latched;
    token_count_next        = token_count;
    flush_used  = 1'b0;
    start_used  = 1'b0;
    second_ok   = 1'b0;
    second_item = make_token(KIND_EOF, pos16, '0, ERR_NONE);

    if (!error_latched) begin
      if (at_end) begin
        second_ok = 1'b1;
        if (scan_mode == MODE_STRING) begin
          error_latched_next = 1'b1;
          second_item.error_code = ERR_STRING;
        end else begin
          flush_used              = 1'b1;
          byte_position_next      = '0;
          token_begin_next        = '0;
          scan_mode_next          = MODE_IDLE;
          dot_seen_next           = 1'b0;
          keyword_candidates_next = '1;
          pending_operator_next   = '0;
          token_count_next        = '0;
        end
      end else begin
        byte_position_next = byte_position + 1'b1;
        case (scan_mode)
          MODE_NUMBER: begin
            if (is_digit(c)) begin
              token_count_next = count_inc;
            end else if (c == ".") begin
              if (dot_seen) begin
                // The number is dropped; only the error goes out.
                error_latched_next = 1'b1;
                second_ok = 1'b1;
                second_item.error_code = ERR_DOTS;
              end else begin
                dot_seen_next    = 1'b1;
                token_count_next = count_inc;
              end
            end else begin
              flush_used = 1'b1;
              start_used = 1'b1;
            end
          end
          MODE_IDENT: begin
            if (is_alpha(c) || is_digit(c) || c == "_") begin
              keyword_candidates_next = kw_filter(keyword_candidates, token_count, c);
              token_count_next        = count_inc;
            end else begin
              flush_used = 1'b1;
              start_used = 1'b1;
            end
          end
          MODE_STRING: begin
            if (c == "\"") begin
              second_ok      = 1'b1;
              second_item    = make_token(KIND_STRING, START_BITS'(token_begin),
                                          token_count, ERR_NONE);
              scan_mode_next = MODE_IDLE;
            end else begin
              token_count_next = count_inc;
            end
          end
          MODE_OPER: begin
            if (op_second(pending_operator) != 8'h00 && c == op_second(pending_operator)) begin
              second_ok      = 1'b1;
              second_item    = make_token(op_two(pending_operator), START_BITS'(token_begin),
                                          LEN_BITS'(2), ERR_NONE);
              scan_mode_next = MODE_IDLE;
            end else begin
              flush_used = 1'b1;
              start_used = 1'b1;
            end
          end
          default: start_used = 1'b1;
        endcase

        if (start_used) begin
          scan_mode_next = MODE_IDLE;
          if (is_space(c)) begin
            scan_mode_next = MODE_IDLE;
          end else if (is_digit(c)) begin
            scan_mode_next   = MODE_NUMBER;
            token_begin_next = byte_position;
            token_count_next = LEN_BITS'(1);
            dot_seen_next    = 1'b0;
          end else if (is_alpha(c) || c == "_") begin
            scan_mode_next          = MODE_IDENT;
            token_begin_next        = byte_position;
            keyword_candidates_next = kw_filter('1, '0, c);
            token_count_next        = LEN_BITS'(1);
          end else if (c == "\"") begin
            scan_mode_next   = MODE_STRING;
            token_begin_next = byte_position + 1'b1;
            token_count_next = '0;
          end else if (op_one(c) != KIND_EOF) begin
            scan_mode_next        = MODE_OPER;
            pending_operator_next = c;
            token_begin_next      = byte_position;
          end else if (single_kind(c) != KIND_EOF) begin
            second_ok   = 1'b1;
            second_item = make_token(single_kind(c), pos16, LEN_BITS'(1), ERR_NONE);
          end else begin
            error_latched_next     = 1'b1;
            second_ok              = 1'b1;
            second_item.error_code = ERR_UNKNOWN;
          end
        end
      end
    end
  end

  // Pack the closed token and the byte's own token, marking the last one.
  always_comb begin
    res0      = second_item;
    res1      = second_item;
    res_count = 2'd0;
    if (flush_used && flush_ok) begin
      res0 = flush_item;
      if (second_ok) begin
        res_count = 2'd2;
        res1.last_of_run = 1'b1;
      end else begin
        res_count = 2'd1;
        res0.last_of_run = 1'b1;
      end
    end else if (second_ok) begin
      res_count = 2'd1;
      res0.last_of_run = 1'b1;
    end
  end

  assign text.ready   = fifo_count <= CNT_BITS'(FIFO_DEPTH - 2);
  assign accept       = text.valid && text.ready;
  assign tokens.valid = fifo_count != '0;
  assign tokens.data  = fifo_mem[rd_ptr];
  assign pop          = tokens.valid && tokens.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position      <= '0;
      token_begin        <= '0;
      scan_mode          <= MODE_IDLE;
      dot_seen           <= 1'b0;
      keyword_candidates <= '1;
      pending_operator   <= '0;
      error_latched      <= 1'b0;
      token_count        <= '0;
    end else if (accept) begin
      byte_position      <= byte_position_next;
      token_begin        <= token_begin_next;
      scan_mode          <= scan_mode_next;
      dot_seen           <= dot_seen_next;
      keyword_candidates <= keyword_candidates_next;
      pending_operator   <= pending_operator_next;
      error_latched      <= error_latched_next;
      token_count        <= token_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr     <= '0;
      rd_ptr     <= '0;
      fifo_count <= '0;
    end else begin
      wr_ptr     <= wr_ptr + (accept ? PTR_BITS'(res_count) : PTR_BITS'(0));
      rd_ptr     <= rd_ptr + PTR_BITS'(pop);
      fifo_count <= fifo_count + (accept ? CNT_BITS'(res_count) : CNT_BITS'(0))
                    - CNT_BITS'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (accept && res_count != 2'd0) begin
      fifo_mem[wr_ptr] <= res0;
    end
    if (accept && res_count == 2'd2) begin
      fifo_mem[wr_ptr + 1'b1] <= res1;
    end
  end

`ifndef SYNTHESIS
  a_fifo_bound: assert property (@(posedge clk) disable iff (rst)
    fifo_count <= CNT_BITS'(FIFO_DEPTH))
    else $error("token queue count beyond its depth");

  a_error_sticks: assert property (@(posedge clk) disable iff (rst)
    error_latched |=> error_latched)
    else $error("latched error cleared without reset");

  a_silent_after_error: assert property (@(posedge clk) disable iff (rst)
    (accept && error_latched) |-> res_count == 2'd0)
    else $error("token produced after a latched error");

  a_token_visible: assert property (@(posedge clk) disable iff (rst)
    (accept && res_count != 2'd0) |=> tokens.valid)
    else $error("token written but queue shows empty");

  a_last_marks: assert property (@(posedge clk) disable iff (rst)
    (accept && res_count == 2'd2) |-> (!res0.last_of_run && res1.last_of_run))
    else $error("end-of-run mark on the wrong token");
`endif

endmodule

// ===== dv/tb_source_token_lexer.sv =====
`timescale 1ns / 1ps

module tb_source_token_lexer;
  import stl_pkg::*;

  localparam int POS_BITS     = 16;
  localparam int RANDOM_ITEMS = 1250;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int DRAIN_CYCLES = 20;
  // A longer string right after an end mark, so it opens at position 0.
  localparam int LONG_BODY    = 48;

  typedef enum logic [2:0] {
    SCAN_IDLE, SCAN_NUMBER, SCAN_WORD, SCAN_STRING, SCAN_OPER
  } scan_e;

  typedef struct packed {
    logic [BYTE_BITS-1:0] text_byte;
    logic                 eos;
    logic                 typed;
    stl_token_t           tok;
  } text_row_t;

  localparam stl_token_t EOF_AT_ZERO = '{KIND_EOF, 16'd0, 16'd0, ERR_NONE, 1'b1};
  localparam stl_token_t NO_CHECK    = '0;

  logic clk = 1'b0;
  logic rst;

  stl_text_if  text_ch ();
  stl_token_if token_ch ();

  source_token_lexer #(.POSITION_BITS(POS_BITS)) uut (
    .clk    (clk),
    .rst    (rst),
    .text   (text_ch),
    .tokens (token_ch)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Lexer state as the testbench sees it.
  scan_e                 scan;
  logic [POS_BITS-1:0]   cur_pos;
  logic [POS_BITS-1:0]   tok_pos;
  logic [LEN_BITS-1:0]   tok_len;
  logic                  seen_dot;
  logic                  halted;
  logic [BYTE_BITS-1:0]  op_byte;
  logic [BYTE_BITS-1:0]  word_buf [0:6];

  stl_token_t step_toks [$];
  stl_token_t expected_tokens [$];

  string kw_names [7] = '{"if", "then", "else", "let", "in", "extern", "new"};
  string word_chars   = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
  string op_chars     = "+-*/%=:!<>,;(){}#";

  int unsigned mismatches = 0;
  int unsigned items_sent = 0;
  int unsigned cycles     = 0;
  int          stall_left = 0;
  bit          idling     = 1'b1;

  text_row_t script [17] = '{
    '{8'hFF, 1'b1, 1'b1, EOF_AT_ZERO},
    '{8'h00, 1'b0, 1'b1, EOF_AT_ZERO},
    '{"9",   1'b0, 1'b0, NO_CHECK},
    '{".",   1'b0, 1'b0, NO_CHECK},
    '{"5",   1'b0, 1'b0, NO_CHECK},
    '{"+",   1'b0, 1'b0, NO_CHECK},
    '{".",   1'b0, 1'b0, NO_CHECK},
    '{"_",   1'b0, 1'b0, NO_CHECK},
    '{"=",   1'b0, 1'b0, NO_CHECK},
    '{"=",   1'b0, 1'b0, NO_CHECK},
    '{"\"",  1'b0, 1'b0, NO_CHECK},
    '{"\"",  1'b0, 1'b0, NO_CHECK},
    '{"<",   1'b0, 1'b0, NO_CHECK},
    '{"#",   1'b0, 1'b0, NO_CHECK},
    '{"i",   1'b0, 1'b0, NO_CHECK},
    '{"n",   1'b0, 1'b0, NO_CHECK},
    '{8'h5A, 1'b1, 1'b0, NO_CHECK}
  };

  function automatic bit dec_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit alpha_char(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic bit blank_char(logic [7:0] c);
    return c == " " || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic bit word_char(logic [7:0] c);
    return alpha_char(c) || dec_digit(c) || c == "_";
  endfunction

  function automatic void oper_kinds(input logic [7:0] c, output logic [KIND_BITS-1:0] one,
                                     output logic [KIND_BITS-1:0] two,
                                     output logic [7:0] second);
    one = KIND_EOF;
    two = KIND_EOF;
    second = 8'h00;
    case (c)
      "+": begin one = KIND_PLUS;    two = KIND_PLUS_DOT;    second = "."; end
      "-": begin one = KIND_MINUS;   two = KIND_MINUS_DOT;   second = "."; end
      "*": begin one = KIND_STAR;    two = KIND_STAR_DOT;    second = "."; end
      "/": begin one = KIND_SLASH;   two = KIND_SLASH_DOT;   second = "."; end
      "%": begin one = KIND_PERCENT; two = KIND_PERCENT_DOT; second = "."; end
      "=": begin one = KIND_EQ;      two = KIND_EQ_EQ;       second = "="; end
      ":": begin one = KIND_COLON;   two = KIND_ASSIGN;      second = "="; end
      "!": begin one = KIND_NOT;     two = KIND_NOT_EQ;      second = "="; end
      ">": begin one = KIND_GT;      two = KIND_GT_EQ;       second = "="; end
      "<": begin one = KIND_LT;      two = KIND_LT_EQ;       second = "="; end
      default: ;
    endcase
  endfunction

  function automatic logic [KIND_BITS-1:0] punct_kind(logic [7:0] c);
    case (c)
      ",": return KIND_COMMA;
      ";": return KIND_SEMI;
      "(": return KIND_LPAREN;
      ")": return KIND_RPAREN;
      "{": return KIND_LBRACE;
      "}": return KIND_RBRACE;
      "#": return KIND_HASH;
      default: return KIND_EOF;
    endcase
  endfunction

  function automatic bit known_start(logic [7:0] c);
    logic [KIND_BITS-1:0] one, two;
    logic [7:0] second;
    oper_kinds(c, one, two, second);
    return blank_char(c) || word_char(c) || c == "\"" || one != KIND_EOF ||
           punct_kind(c) != KIND_EOF;
  endfunction

  function automatic void clear_state();
    scan = SCAN_IDLE;
    cur_pos = '0;
    tok_pos = '0;
    tok_len = '0;
    seen_dot = 1'b0;
    halted = 1'b0;
    op_byte = 8'h00;
  endfunction

  function automatic void emit(logic [KIND_BITS-1:0] kind, logic [POS_BITS-1:0] at,
                               logic [LEN_BITS-1:0] len, logic [ERR_BITS-1:0] err);
    stl_token_t t;
    t.token_kind   = kind;
    t.token_start  = START_BITS'(at);
    t.token_length = len;
    t.error_code   = err;
    t.last_of_run  = 1'b0;
    step_toks = {step_toks, t};
  endfunction

  function automatic void bump();
    if (tok_len != LEN_MAX) tok_len = tok_len + 1'b1;
  endfunction

  function automatic logic [KIND_BITS-1:0] word_kind();
    logic [KIND_BITS-1:0] kind;
    bit same;
    kind = KIND_IDENT;
    for (int k = 0; k < 7; k++) begin
      if (kw_names[k].len() == tok_len) begin
        same = 1'b1;
        for (int i = 0; i < kw_names[k].len(); i++) begin
          if (kw_names[k][i] != word_buf[i]) same = 1'b0;
        end
        if (same) kind = KIND_KW_IF + KIND_BITS'(k);
      end
    end
    return kind;
  endfunction

  function automatic void flush_pending();
    logic [KIND_BITS-1:0] one, two;
    logic [7:0] second;
    case (scan)
      SCAN_NUMBER: emit(seen_dot ? KIND_FLOAT : KIND_NUMBER, tok_pos, tok_len, ERR_NONE);
      SCAN_WORD:   emit(word_kind(), tok_pos, tok_len, ERR_NONE);
      SCAN_OPER: begin
        oper_kinds(op_byte, one, two, second);
        emit(one, tok_pos, 16'd1, ERR_NONE);
      end
      default: ;
    endcase
    scan = SCAN_IDLE;
  endfunction

  function automatic void begin_token(logic [7:0] c);
    logic [KIND_BITS-1:0] one, two;
    logic [7:0] second;
    oper_kinds(c, one, two, second);
    scan = SCAN_IDLE;
    if (blank_char(c)) begin
      return;
    end else if (dec_digit(c)) begin
      scan = SCAN_NUMBER;
      tok_pos = cur_pos;
      tok_len = 16'd1;
      seen_dot = 1'b0;
    end else if (alpha_char(c) || c == "_") begin
      scan = SCAN_WORD;
      tok_pos = cur_pos;
      tok_len = 16'd1;
      word_buf[0] = c;
    end else if (c == "\"") begin
      scan = SCAN_STRING;
      tok_pos = cur_pos + 1'b1;
      tok_len = '0;
    end else if (one != KIND_EOF) begin
      scan = SCAN_OPER;
      op_byte = c;
      tok_pos = cur_pos;
    end else if (punct_kind(c) != KIND_EOF) begin
      emit(punct_kind(c), cur_pos, 16'd1, ERR_NONE);
    end else begin
      halted = 1'b1;
      emit(KIND_EOF, cur_pos, '0, ERR_UNKNOWN);
    end
  endfunction

  // Works out the tokens that one accepted item completes.
  function automatic void lex_step(logic [7:0] c, logic eos);
    logic [KIND_BITS-1:0] one, two;
    logic [7:0] second;
    step_toks.delete();
    if (halted) return;
    if (eos || c == 8'h00) begin
      if (scan == SCAN_STRING) begin
        halted = 1'b1;
        emit(KIND_EOF, cur_pos, '0, ERR_STRING);
      end else begin
        flush_pending();
        emit(KIND_EOF, cur_pos, '0, ERR_NONE);
        clear_state();
      end
    end else begin
      case (scan)
        SCAN_NUMBER: begin
          if (dec_digit(c)) begin
            bump();
          end else if (c == ".") begin
            if (seen_dot) begin
              halted = 1'b1;
              emit(KIND_EOF, cur_pos, '0, ERR_DOTS);
            end else begin
              seen_dot = 1'b1;
              bump();
            end
          end else begin
            flush_pending();
            begin_token(c);
          end
        end
        SCAN_WORD: begin
          if (word_char(c)) begin
            if (tok_len < 7) word_buf[tok_len] = c;
            bump();
          end else begin
            flush_pending();
            begin_token(c);
          end
        end
        SCAN_STRING: begin
          if (c == "\"") begin
            emit(KIND_STRING, tok_pos, tok_len, ERR_NONE);
            scan = SCAN_IDLE;
          end else begin
            bump();
          end
        end
        SCAN_OPER: begin
          oper_kinds(op_byte, one, two, second);
          if (second != 8'h00 && c == second) begin
            emit(two, tok_pos, 16'd2, ERR_NONE);
            scan = SCAN_IDLE;
          end else begin
            flush_pending();
            begin_token(c);
          end
        end
        default: begin_token(c);
      endcase
      cur_pos = cur_pos + 1'b1;
    end
    if (step_toks.size() > 0) step_toks[step_toks.size()-1].last_of_run = 1'b1;
  endfunction

  // True when the item would raise an error in the current scan state.
  function automatic bit breaks_text(logic [7:0] c, logic eos);
    logic [KIND_BITS-1:0] one, two;
    logic [7:0] second;
    oper_kinds(op_byte, one, two, second);
    if (eos || c == 8'h00) return scan == SCAN_STRING;
    case (scan)
      SCAN_STRING: return 1'b0;
      SCAN_NUMBER: begin
        if (dec_digit(c)) return 1'b0;
        else if (c == ".") return seen_dot;
        else return !known_start(c);
      end
      SCAN_WORD: return !word_char(c) && !known_start(c);
      SCAN_OPER: return !(second != 8'h00 && c == second) && !known_start(c);
      default: return !known_start(c);
    endcase
  endfunction

  function automatic logic [7:0] text_byte();
    logic [7:0] b;
    b = 8'($urandom_range(1, 255));
    if (b == "\"") b = "'";
    return b;
  endfunction

  task automatic drive_item(input logic [7:0] b, input logic eos);
    int gap;
    @(negedge clk);
    if (idling && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 3);
      text_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    text_ch.valid <= 1'b1;
    text_ch.data  <= {b, eos};
    do @(posedge clk); while (!text_ch.ready);
  endtask

  task automatic send_item(input logic [7:0] b, input logic eos);
    drive_item(b, eos);
    lex_step(b, eos);
    expected_tokens = {expected_tokens, step_toks};
    items_sent++;
  endtask

  // Keeps the random text free of errors: an item that would raise one becomes a blank.
  task automatic put_byte(input logic [7:0] b, input logic eos);
    if (breaks_text(b, eos)) send_item(" ", 1'b0);
    else send_item(b, eos);
  endtask

  task automatic random_piece();
    logic [7:0] piece [$];
    logic [KIND_BITS-1:0] one, two;
    logic [7:0] second;
    int n;
    int k;
    case ($urandom_range(0, 19))
      0, 1, 2: begin
        n = $urandom_range(1, 3);
        repeat (n) piece = {piece, (($urandom_range(0, 1) == 0) ? 8'h20 :
                                    8'($urandom_range(9, 13)))};
      end
      3, 4, 5: begin
        n = $urandom_range(1, 5);
        repeat (n) piece = {piece, 8'("0" + $urandom_range(0, 9))};
        if ($urandom_range(0, 2) == 0) begin
          piece = {piece, 8'(".")};
          n = $urandom_range(0, 3);
          repeat (n) piece = {piece, 8'("0" + $urandom_range(0, 9))};
        end
      end
      6, 7, 8, 9: begin
        k = $urandom_range(0, 9);
        if (k < 7) begin
          for (int i = 0; i < kw_names[k].len(); i++) piece = {piece, kw_names[k][i]};
          // Near misses: a keyword cut short or grown by one character, or left whole.
          case ($urandom_range(0, 3))
            0: void'(piece.pop_back());
            1: piece = {piece, word_chars[$urandom_range(0, 62)]};
            default: ;
          endcase
        end else begin
          piece = {piece, word_chars[$urandom_range(0, 52)]};
          n = $urandom_range(0, 8);
          repeat (n) piece = {piece, word_chars[$urandom_range(0, 62)]};
        end
      end
      10, 11: begin
        piece = {piece, 8'("\"")};
        n = $urandom_range(0, 12);
        repeat (n) piece = {piece, text_byte()};
        piece = {piece, 8'("\"")};
      end
      12, 13, 14, 15, 16: begin
        piece = {piece, op_chars[$urandom_range(0, op_chars.len() - 1)]};
        oper_kinds(piece[0], one, two, second);
        if (second != 8'h00 && $urandom_range(0, 1) == 0) piece = {piece, second};
      end
      17: begin
        if ($urandom_range(0, 1) == 0) put_byte(8'($urandom), 1'b1);
        else put_byte(8'h00, 1'b0);
      end
      default: put_byte(8'($urandom), $urandom_range(0, 7) == 0);
    endcase
    foreach (piece[i]) put_byte(piece[i], 1'b0);
  endtask

  function automatic void log_mismatch(string what, stl_token_t want, stl_token_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t: %s: expected kind %0d start %0d length %0d error %0d last %0d,",
               $time, what, want.token_kind, want.token_start, want.token_length,
               want.error_code, want.last_of_run);
      $display("    got kind %0d start %0d length %0d error %0d last %0d",
               got.token_kind, got.token_start, got.token_length, got.error_code,
               got.last_of_run);
    end
  endfunction

  always @(negedge clk) begin
    if (stall_left > 0) stall_left--;
    else if (idling && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 3);
    token_ch.ready <= (stall_left == 0);
  end

  always @(posedge clk) begin : check_tokens
    stl_token_t want;
    stl_token_t got;
    if (!rst && token_ch.valid && token_ch.ready) begin
      got = token_ch.data;
      if (expected_tokens.size() == 0) begin
        log_mismatch("token with nothing expected", NO_CHECK, got);
      end else begin
        want = expected_tokens.pop_front();
        if (got.token_kind !== want.token_kind || got.token_start !== want.token_start ||
            got.token_length !== want.token_length || got.error_code !== want.error_code ||
            got.last_of_run !== want.last_of_run)
          log_mismatch("token mismatch", want, got);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    text_row_t row;
    int pieces;
    logic [ERR_BITS-1:0] tail_err;
    logic [7:0] bad;
    rst = 1'b1;
    text_ch.valid = 1'b0;
    text_ch.data = '0;
    token_ch.ready = 1'b0;
    clear_state();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed text; typed rows carry their token, the rest go through the predictor.
    for (int i = 0; i < 17; i++) begin
      row = script[i];
      if (row.typed) begin
        drive_item(row.text_byte, row.eos);
        lex_step(row.text_byte, row.eos);
        expected_tokens = {expected_tokens, row.tok};
        items_sent++;
      end else begin
        send_item(row.text_byte, row.eos);
      end
    end

    pieces = 0;
    while (items_sent < RANDOM_ITEMS) begin
      if (pieces % 50 == 0) idling = ($urandom_range(0, 3) != 0);
      random_piece();
      pieces++;
    end

    // From here on both sides run flat out.
    idling = 1'b0;
    if (scan == SCAN_STRING) send_item("\"", 1'b0);
    send_item(8'h00, 1'b1);
    send_item("\"", 1'b0);
    repeat (LONG_BODY) send_item(text_byte(), 1'b0);
    send_item("\"", 1'b0);
    send_item("#", 1'b0);

    // An error latches until reset, so exactly one kind ends the run.
    tail_err = ERR_BITS'($urandom_range(1, 3));
    case (tail_err)
      ERR_DOTS: begin
        send_item(" ", 1'b0);
        send_item("1", 1'b0);
        send_item(".", 1'b0);
        send_item(".", 1'b0);
      end
      ERR_STRING: begin
        send_item("\"", 1'b0);
        send_item("a", 1'b0);
        send_item(8'($urandom), 1'b1);
      end
      default: begin
        if ($urandom_range(0, 2) == 0) begin
          bad = ".";
        end else begin
          do bad = 8'($urandom_range(1, 255)); while (known_start(bad));
        end
        send_item("a", 1'b0);
        send_item("b", 1'b0);
        send_item(bad, 1'b0);
      end
    endcase
    repeat (24) send_item(8'($urandom), $urandom_range(0, 1) == 1);

    @(negedge clk);
    text_ch.valid <= 1'b0;
    while (expected_tokens.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
